/* sv/assert_macros.svh */
// Assertion macros for the RTL of this block.
// Every macro samples on the rising edge of i_clk of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The check is switched off while i_rst_n is low.
`define PAD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// The check holds at every edge, during reset too.
`define PAD_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/pad_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pad_pkg;
    localparam int CHANNELS_DEF = 8192;
    localparam int CAP_IDS      = 4;

    localparam int SUM_W = 31;
    localparam int CNT_W = 24;
    localparam int EVT_W = 20;

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 32;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_EVENT  = 2'd1;
    localparam logic [1:0] REQ_TUNE   = 2'd2;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_APD    = 2'd1;
    localparam logic [1:0] CFG_SPE    = 2'd2;
    localparam logic [1:0] CFG_TEN    = 2'd3;

    localparam logic [10:0] TARGET_RST = 11'd48;
    localparam logic [7:0]  APD_RST    = 8'd16;
    localparam logic [3:0]  SPE_RST    = 4'd10;
    localparam logic        TEN_RST    = 1'b1;
endpackage
`default_nettype wire

/* sv/pad_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pad_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [12:0] channel;
    logic [1:0]  cap_id;
    logic [6:0]  adc;
    logic [2:0]  old_dac;
    logic        fixed_dac;

    modport source (output valid, req_type, channel, cap_id, adc, old_dac, fixed_dac,
                    input ready);
    modport sink (input valid, req_type, channel, cap_id, adc, old_dac, fixed_dac,
                  output ready);
endinterface

interface pad_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  new_dac;
    logic        needs_tuning;
    logic        skipped;
    logic        partial_caps;
    logic [10:0] pedestal;
    logic [8:0]  stability;

    modport source (output valid, new_dac, needs_tuning, skipped, partial_caps, pedestal,
                    stability, input ready);
    modport sink (input valid, new_dac, needs_tuning, skipped, partial_caps, pedestal,
                  stability, output ready);
endinterface

interface pad_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/pedestal_accumulate_and_dac_tune.sv */
// Sample items do a store read, then a write back; end-of-event items do neither.
// Tune requests do four store reads, then up to three passes of the shared
// restoring divider.
// Reset is synchronous, active low; it restores the register defaults and then
// runs a clearing pass over the store, with no item taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pedestal_accumulate_and_dac_tune #(
    parameter int CHANNELS = pad_pkg::CHANNELS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pad_in_if.sink     i_in,
    pad_out_if.source  o_out,
    pad_cfg_if.sink    i_cfg
);
    import pad_pkg::*;

    localparam int DEPTH = CHANNELS * CAP_IDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = SUM_W + CNT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [14:0]   CH_LIM    = 15'(CHANNELS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_UPD, S_ACC, S_PED_GO, S_PED_WT,
        S_STB_GO, S_STB_WT, S_STP_GO, S_STP_WT, S_OUT
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [10:0] r_target;
    logic [7:0]  r_apd;
    logic [3:0]  r_spe;
    logic        r_ten;

    logic [EVT_W-1:0] r_evt;
    logic [AW-1:0]    r_clr;

    // Captured item.
    logic [AW-1:0] r_addr;
    logic [12:0]   r_ch;
    logic [6:0]    r_adc;
    logic [2:0]    r_old;
    logic          r_fixed;
    logic          r_ch_ok;
    logic [1:0]    r_k;

    // Tune working registers.
    logic [SUM_W+1:0] r_sum;
    logic [CNT_W+1:0] r_tot;
    logic [2:0]       r_seen;
    logic [23:0]      r_den_stab;
    logic [10:0]      r_ped;
    logic [8:0]       r_stab;
    logic [11:0]      r_step;
    logic             r_dneg;
    logic             r_tuned;

    // Output register.
    logic        r_ov;
    logic [2:0]  r_o_dac;
    logic        r_o_needs;
    logic        r_o_skip;
    logic        r_o_part;
    logic [10:0] r_o_ped;
    logic [8:0]  r_o_stab;

    logic          w_in_acc;
    logic          w_ch_ok;
    logic [AW-1:0] w_in_addr;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [CNT_W-1:0] w_cnt;
    logic [SUM_W-1:0] w_sum;

    logic                 w_div_start;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_div_quo;

    logic signed [11:0] w_d;
    logic [11:0]        w_mag;
    logic [7:0]         w_a;
    logic signed [13:0] w_nd;
    logic [2:0]         w_nd_clamp;
    logic               w_skip;
    logic               w_out_free;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_ch_ok    = {2'b00, i_in.channel} < CH_LIM;

    // A tune request starts its sweep at capacitor id zero.
    assign w_in_addr = AW'({i_in.channel,
                            (i_in.req_type == REQ_TUNE) ? 2'b00 : i_in.cap_id});

    // The read address comes straight from the input port in the idle state so
    // that the stored entry is available in the cycle right after acceptance.
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = w_in_addr;
            S_ACC:   w_raddr = AW'({r_ch, r_k + 2'd1});
            default: w_raddr = r_addr;
        endcase
    end

    assign w_cnt = w_rdata[CNT_W-1:0];
    assign w_sum = w_rdata[EW-1:CNT_W];

    // Write port: the clearing pass after reset, or the sample write-back. A
    // sample whose count is already full is dropped entirely.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = {SUM_W'(w_sum + SUM_W'(r_adc)), CNT_W'(w_cnt + 1'b1)};
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_UPD) begin
            w_we = r_ch_ok && (w_cnt != {CNT_W{1'b1}});
        end
    end

    pad_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Step toward the target: (2|d| + a) / 2a gives rounding half away from zero.
    assign w_d   = $signed({1'b0, r_target}) - $signed({1'b0, r_ped});
    assign w_mag = w_d[11] ? 12'(-w_d) : 12'(w_d);
    assign w_a   = (r_apd == 8'd0) ? 8'd1 : r_apd;

    // Operand selection for the shared divider.
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        unique case (r_state)
            S_PED_GO: begin
                w_div_start = (r_tot != '0);
                w_div_num   = DIV_NUM_W'({r_sum, 5'b0}) + DIV_NUM_W'(r_tot);
                w_div_den   = DIV_DEN_W'({r_tot, 1'b0});
            end
            S_STB_GO: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'({r_tot, 8'b0});
                w_div_den   = DIV_DEN_W'(r_den_stab);
            end
            S_STP_GO: begin
                w_div_start = !r_fixed && r_ten;
                w_div_num   = DIV_NUM_W'({w_mag, 1'b0}) + DIV_NUM_W'(w_a);
                w_div_den   = DIV_DEN_W'({w_a, 1'b0});
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    pad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Final setting: old plus signed step, clamped to the DAC range.
    assign w_nd = r_dneg ? $signed({11'b0, r_old}) - $signed({2'b0, r_step})
                         : $signed({11'b0, r_old}) + $signed({2'b0, r_step});
    always_comb begin
        priority if (w_nd < 14'sd0) begin
            w_nd_clamp = 3'd0;
        end else if (w_nd > 14'sd7) begin
            w_nd_clamp = 3'd7;
        end else begin
            w_nd_clamp = w_nd[2:0];
        end
    end
    assign w_skip     = (r_tot == '0) || r_fixed;
    assign w_out_free = !r_ov || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: begin
                if (w_in_acc && i_in.req_type == REQ_SAMPLE) n_state = S_UPD;
                if (w_in_acc && i_in.req_type == REQ_TUNE)   n_state = S_ACC;
            end
            S_UPD:    n_state = S_IDLE;
            S_ACC:    if (r_k == 2'd3) n_state = S_PED_GO;
            S_PED_GO: n_state = (r_tot == '0) ? S_OUT : S_PED_WT;
            S_PED_WT: if (w_div_done) n_state = (r_den_stab == '0) ? S_STP_GO : S_STB_GO;
            S_STB_GO: n_state = S_STB_WT;
            S_STB_WT: if (w_div_done) n_state = S_STP_GO;
            S_STP_GO: n_state = (!r_fixed && r_ten) ? S_STP_WT : S_OUT;
            S_STP_WT: if (w_div_done) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_evt    <= '0;
            r_ov     <= 1'b0;
            r_target <= TARGET_RST;
            r_apd    <= APD_RST;
            r_spe    <= SPE_RST;
            r_ten    <= TEN_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_TARGET: r_target <= i_cfg.data;
                    CFG_APD:    r_apd    <= i_cfg.data[7:0];
                    CFG_SPE:    r_spe    <= i_cfg.data[3:0];
                    CFG_TEN:    r_ten    <= i_cfg.data[0];
                endcase
            end

            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end

            // A new result reloads the output register in the same cycle that
            // the previous one leaves, so valid stays high across the swap.
            if (r_state == S_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end

            if (w_in_acc) begin
                r_addr  <= w_in_addr;
                r_ch    <= i_in.channel;
                r_adc   <= i_in.adc;
                r_old   <= i_in.old_dac;
                r_fixed <= i_in.fixed_dac;
                r_ch_ok <= w_ch_ok;
                r_k     <= 2'd0;
                r_sum   <= '0;
                r_tot   <= '0;
                r_seen  <= '0;
                r_ped   <= '0;
                r_stab  <= '0;
                r_step  <= '0;
                r_tuned <= 1'b0;
                if (i_in.req_type == REQ_EVENT && r_evt != {EVT_W{1'b1}}) begin
                    r_evt <= r_evt + 1'b1;
                end
            end

            if (r_state == S_ACC) begin
                r_k        <= r_k + 1'b1;
                r_den_stab <= r_spe * r_evt;
                if (r_ch_ok) begin
                    r_sum  <= r_sum + (SUM_W+2)'(w_sum);
                    r_tot  <= r_tot + (CNT_W+2)'(w_cnt);
                    r_seen <= r_seen + 3'(w_cnt != '0);
                end
            end

            if (r_state == S_PED_WT && w_div_done) begin
                r_ped <= (w_div_quo[DIV_NUM_W-1:11] != '0) ? 11'h7FF : w_div_quo[10:0];
                if (r_den_stab == '0) begin
                    r_stab <= 9'h1FF;
                end
            end

            if (r_state == S_STB_WT && w_div_done) begin
                r_stab <= (w_div_quo[DIV_NUM_W-1:9] != '0) ? 9'h1FF : w_div_quo[8:0];
            end

            if (r_state == S_STP_GO) begin
                r_dneg <= w_d[11];
            end

            if (r_state == S_STP_WT && w_div_done) begin
                r_step  <= w_div_quo[11:0];
                r_tuned <= 1'b1;
            end

            if (r_state == S_OUT && w_out_free) begin
                r_o_dac   <= r_tuned ? w_nd_clamp : r_old;
                r_o_needs <= r_tuned && (r_step != '0);
                r_o_skip  <= w_skip;
                r_o_part  <= (r_seen != 3'd0) && (r_seen != 3'(CAP_IDS));
                r_o_ped   <= r_ped;
                r_o_stab  <= r_stab;
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.new_dac      = r_o_dac;
    assign o_out.needs_tuning = r_o_needs;
    assign o_out.skipped      = r_o_skip;
    assign o_out.partial_caps = r_o_part;
    assign o_out.pedestal     = r_o_ped;
    assign o_out.stability    = r_o_stab;

    // No item may enter while the store is still being cleared.
    `PAD_ASSERT_ANY(a_clr_blocks_input, (r_state == S_CLR) |-> !i_in.ready, "input open during clear")
    // The store is written only by the clearing pass or a sample write-back.
    `PAD_ASSERT_RST(a_store_write_src, w_we |-> (r_state == S_CLR || r_state == S_UPD), "stray write")
    // A new result appears only after the sequencer reached its output step.
    `PAD_ASSERT_RST(a_result_from_seq, $rose(r_ov) |-> $past(r_state == S_OUT), "result without tune")
endmodule
`default_nettype wire

/* sv/pad_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module pad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/pad_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module pad_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pad_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [pad_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                                o_done,
    output logic      [pad_pkg::DIV_NUM_W-1:0]  o_quo
);
    import pad_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W);
    localparam logic [CW-1:0] LAST = CW'(DIV_NUM_W - 1);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of r_quo while quotient bits shift in at the bottom.
    assign w_trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den})
                              : w_trial[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quo = r_quo;
endmodule
`default_nettype wire

/* dv/pad_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module pad_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pad_in_if         i_in,
    pad_out_if        i_out,
    pad_cfg_if        i_cfg,
    output int        o_errors,
    output int        o_pending
);
    import pad_pkg::*;

    typedef struct packed {
        logic [2:0]  new_dac;
        logic        needs_tuning;
        logic        skipped;
        logic        partial_caps;
        logic [10:0] pedestal;
        logic [8:0]  stability;
    } t_tune_result;

    localparam int NUM_CH = CHANNELS_DEF;

    logic [SUM_W-1:0] sum_store [int];
    logic [CNT_W-1:0] cnt_store [int];
    logic [EVT_W-1:0] events;
    logic [10:0] target;
    logic [7:0]  adc_per_step;
    logic [3:0]  samp_per_evt;
    logic        tune_on;
    t_tune_result expected_tunes [$];

    assign o_pending = expected_tunes.size();

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, field, want, got);
        o_errors++;
    endtask

    // Works out the answer to a tune request from the current store contents.
    function automatic t_tune_result predict_tune(input int ch, input logic [2:0] old_dac,
                                                  input logic fixed);
        t_tune_result r;
        longint sum_all, total, ped, stab, denom, d, mag, a, stp, nd;
        int caps_seen, idx;
        sum_all = 0;
        total = 0;
        caps_seen = 0;
        if (ch < NUM_CH) begin
            for (int k = 0; k < CAP_IDS; k++) begin
                idx = ch * CAP_IDS + k;
                if (cnt_store.exists(idx) && cnt_store[idx] != 0) begin
                    sum_all += sum_store[idx];
                    total += cnt_store[idx];
                    caps_seen++;
                end
            end
        end
        ped = (total > 0) ? (sum_all * 32 + total) / (2 * total) : 0;
        if (ped > 2047) ped = 2047;
        denom = longint'(samp_per_evt) * longint'(events);
        if (total == 0) stab = 0;
        else if (denom == 0) stab = 511;
        else begin
            stab = (total * 256) / denom;
            if (stab > 511) stab = 511;
        end
        r.skipped = (total == 0) || fixed;
        r.partial_caps = (caps_seen > 0) && (caps_seen < CAP_IDS);
        r.pedestal = ped[10:0];
        r.stability = stab[8:0];
        r.new_dac = old_dac;
        r.needs_tuning = 1'b0;
        if (!r.skipped && tune_on) begin
            d = longint'(target) - ped;
            a = (adc_per_step == 0) ? 1 : adc_per_step;
            mag = (d < 0) ? -d : d;
            stp = (2 * mag + a) / (2 * a);
            if (d < 0) stp = -stp;
            nd = longint'(old_dac) + stp;
            r.needs_tuning = (stp != 0);
            if (nd > 7) nd = 7;
            if (nd < 0) nd = 0;
            r.new_dac = nd[2:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        int idx;
        t_tune_result want;
        t_tune_result got;
        if (!i_rst_n) begin
            sum_store.delete();
            cnt_store.delete();
            events = '0;
            target = TARGET_RST;
            adc_per_step = APD_RST;
            samp_per_evt = SPE_RST;
            tune_on = TEN_RST;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_TARGET: target = i_cfg.data;
                    CFG_APD: adc_per_step = i_cfg.data[7:0];
                    CFG_SPE: samp_per_evt = i_cfg.data[3:0];
                    default: tune_on = i_cfg.data[0];
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.req_type)
                    REQ_SAMPLE: begin
                        if (i_in.channel < NUM_CH) begin
                            idx = i_in.channel * CAP_IDS + i_in.cap_id;
                            if (!cnt_store.exists(idx)) begin
                                cnt_store[idx] = '0;
                                sum_store[idx] = '0;
                            end
                            // A full counter drops the whole sample.
                            if (cnt_store[idx] != '1) begin
                                cnt_store[idx]++;
                                sum_store[idx] += i_in.adc;
                            end
                        end
                    end
                    REQ_EVENT: if (events != '1) events++;
                    REQ_TUNE: expected_tunes.insert(expected_tunes.size(),
                        predict_tune(i_in.channel, i_in.old_dac, i_in.fixed_dac));
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.new_dac, i_out.needs_tuning, i_out.skipped, i_out.partial_caps,
                       i_out.pedestal, i_out.stability};
                if (expected_tunes.size() == 0) begin
                    report_mismatch("results outstanding", 0, 1);
                end else begin
                    want = expected_tunes.pop_front();
                    if (got.new_dac !== want.new_dac)
                        report_mismatch("new_dac", want.new_dac, got.new_dac);
                    if (got.needs_tuning !== want.needs_tuning)
                        report_mismatch("needs_tuning", want.needs_tuning, got.needs_tuning);
                    if (got.skipped !== want.skipped)
                        report_mismatch("skipped", want.skipped, got.skipped);
                    if (got.partial_caps !== want.partial_caps)
                        report_mismatch("partial_caps", want.partial_caps, got.partial_caps);
                    if (got.pedestal !== want.pedestal)
                        report_mismatch("pedestal", want.pedestal, got.pedestal);
                    if (got.stability !== want.stability)
                        report_mismatch("stability", want.stability, got.stability);
                end
            end
        end
    end

    initial o_errors = 0;
endmodule
`default_nettype wire

/* dv/pedestal_accumulate_and_dac_tune_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module pedestal_accumulate_and_dac_tune_tb;
    import pad_pkg::*;

    // Idle cycles allowed before a register write. Sample and event
    // transactions give no result; a tune request gives one.
    localparam int SETTLE_CYCLES = 300;
    // Nothing is accepted during the clearing pass after reset, so the watchdog
    // limit sits well above the length of that pass.
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int PRESSURE_CYCLES = 3000;

    logic i_clk;
    logic i_rst_n;
    int   n_errors;
    int   n_pending;
    int   idle_cycles;
    bit   no_gaps;
    bit   hold_off_req;

    // A small pool of channels keeps the store dense enough that tune
    // requests usually find samples.
    logic [12:0] hot_channels [6];

    pad_in_if  in_ch ();
    pad_out_if out_ch ();
    pad_cfg_if cfg_ch ();

    pedestal_accumulate_and_dac_tune dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pad_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (n_errors),
        .o_pending (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if (no_gaps) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // The result side stalls at random, and on request holds off for a
    // long stretch so that the block fills up and pushes back on its input.
    initial begin
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (pick_gap() != 0) begin
                out_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Counts cycles with no transaction on any channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the
    // transaction is accepted, with valid still high.
    task automatic send_item(input logic [1:0] req, input logic [12:0] ch,
                             input logic [1:0] cap, input logic [6:0] adc,
                             input logic [2:0] old_dac, input logic fixed);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= req;
        in_ch.channel <= ch;
        in_ch.cap_id <= cap;
        in_ch.adc <= adc;
        in_ch.old_dac <= old_dac;
        in_ch.fixed_dac <= fixed;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Register writes happen only once the block has drained.
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        in_ch.valid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all(input logic [10:0] tgt, input logic [10:0] apd,
                             input logic [10:0] spe, input logic [10:0] ten);
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_APD, apd);
        write_reg(CFG_SPE, spe);
        write_reg(CFG_TEN, ten);
    endtask

    // Random traffic, mostly samples on the hot channels with events and
    // tune requests mixed in, plus some unused request codes as noise.
    task automatic random_items(input int count);
        int sel;
        logic [1:0]  req;
        logic [12:0] ch;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) req = REQ_SAMPLE;
            else if (sel < 70) req = REQ_EVENT;
            else if (sel < 95) req = REQ_TUNE;
            else req = 2'd3;
            ch = ($urandom_range(0, 9) == 0) ? 13'($urandom) : hot_channels[$urandom_range(0, 5)];
            send_item(req, ch, 2'($urandom), 7'($urandom), 3'($urandom),
                      $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        no_gaps = 1'b0;
        hold_off_req = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_SAMPLE;
        in_ch.channel = '0;
        in_ch.cap_id = '0;
        in_ch.adc = '0;
        in_ch.old_dac = '0;
        in_ch.fixed_dac = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_TARGET;
        cfg_ch.data = '0;
        hot_channels[0] = 13'd0;
        hot_channels[1] = 13'd8191;
        for (int k = 2; k < 6; k++) hot_channels[k] = 13'($urandom);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset register values.
        // A channel with no samples is skipped and reports zero.
        send_item(REQ_TUNE, 13'd5, 2'd0, 7'd0, 3'd3, 1'b0);
        // Two capacitor ids only: partial, and no events yet gives 511.
        send_item(REQ_SAMPLE, 13'd5, 2'd0, 7'd127, 3'd0, 1'b0);
        send_item(REQ_SAMPLE, 13'd5, 2'd1, 7'd0, 3'd0, 1'b0);
        send_item(REQ_TUNE, 13'd5, 2'd0, 7'd0, 3'd7, 1'b0);
        send_item(REQ_EVENT, 13'd0, 2'd0, 7'd0, 3'd0, 1'b0);
        send_item(REQ_TUNE, 13'd5, 2'd0, 7'd0, 3'd2, 1'b1);
        // All four capacitor ids on the top channel, high and low readings.
        for (int k = 0; k < CAP_IDS; k++)
            send_item(REQ_SAMPLE, 13'd8191, 2'(k), (k % 2) ? 7'd127 : 7'd1, 3'd0, 1'b0);
        send_item(REQ_TUNE, 13'd8191, 2'd3, 7'd0, 3'd0, 1'b0);
        send_item(REQ_TUNE, 13'd8191, 2'd0, 7'd0, 3'd7, 1'b0);
        // The unused request code changes nothing and answers nothing.
        send_item(2'd3, 13'd5, 2'd2, 7'd99, 3'd5, 1'b1);
        send_item(REQ_TUNE, 13'd5, 2'd0, 7'd0, 3'd0, 1'b0);
        // Low pedestal against the default target drives the setting up.
        for (int k = 0; k < CAP_IDS; k++)
            send_item(REQ_SAMPLE, 13'd0, 2'(k), 7'd0, 3'd0, 1'b0);
        send_item(REQ_TUNE, 13'd0, 2'd0, 7'd0, 3'd6, 1'b0);

        // Phases with different settings, extremes among them. A zero
        // step size and a zero samples-per-event are both legal writes.
        write_all(11'd0, 11'd1, 11'd1, 11'd1);
        random_items(50);
        write_all(11'd2047, 11'd255, 11'd15, 11'd1);
        no_gaps = 1'b1;
        random_items(50);
        no_gaps = 1'b0;
        write_all(11'd1000, 11'h700, 11'h7f0, 11'h7fe);
        random_items(50);
        write_all(11'd48, 11'd16, 11'd10, 11'd0);
        random_items(50);

        // The receiver holds off while tune requests pile up behind it.
        write_all(11'($urandom), 11'($urandom), 11'($urandom_range(1, 10)), 11'd1);
        hold_off_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_item(REQ_TUNE, hot_channels[n % 6], 2'd0, 7'd0, 3'($urandom), 1'b0);
        random_items(50);

        for (int p = 0; p < 3; p++) begin
            write_all(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
            random_items(50);
        end

        in_ch.valid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
